// ===== design/tmq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared types and constants for the touch tag majority qualifier.
// ----------------------------------------------------------------------------
package tmq_pkg;

  localparam int unsigned NUM_TAGS_DEF = 12;
  localparam int unsigned TAG_W        = 8;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned HOLD_W       = 16;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned VOTE_W       = 4;

  localparam logic [TAG_W-1:0]  TAG_NONE    = 8'h00;
  localparam logic [TAG_W-1:0]  TAG_INVALID = 8'hFF;
  localparam logic [HOLD_W-1:0] HOLD_RESET  = 16'd20;

  typedef struct packed {
    logic [TAG_W-1:0]  touch_tag;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [VOTE_W-1:0] voted_tag;
    logic              release_event;
  } out_word_t;

endpackage

// ===== design/touch_tag_majority_qualifier.sv =====
// ----------------------------------------------------------------------------
// touch_tag_majority_qualifier
// Majority-vote debounce of touch controller tags over a hold window.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one result word per input word, in the
// cycle after acceptance. The per-tag counter update and the argmax compare
// tree sit between the state registers and the output register, so an input
// word is taken every cycle unless the output register is full and stalled.
// Throughput is one word per cycle while the output is not stalled.
module touch_tag_majority_qualifier #(
  parameter int unsigned NUM_TAGS = tmq_pkg::NUM_TAGS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tmq_pkg::HOLD_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tmq_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tmq_pkg::out_word_t           out_data
);

  localparam int unsigned IW     = $clog2(NUM_TAGS);
  localparam int unsigned LEAVES = 1 << IW;
  localparam int unsigned VW     = (IW + 1 > tmq_pkg::VOTE_W) ? IW + 1 : tmq_pkg::VOTE_W;

  logic [tmq_pkg::HOLD_W-1:0]  hold_ms_r;
  logic                        pressed_r, pressed_nxt;
  logic [tmq_pkg::VOTE_W-1:0]  held_tag_r, held_tag_nxt;
  logic [tmq_pkg::TIME_W-1:0]  press_start_r, start_eff;
  logic [tmq_pkg::CNT_W-1:0]   cnt_r   [NUM_TAGS];
  logic [tmq_pkg::CNT_W-1:0]   cnt_nxt [NUM_TAGS];
  logic                        out_valid_r;
  tmq_pkg::out_word_t          out_data_r, out_data_nxt;

  logic [tmq_pkg::CNT_W-1:0]   node_cnt [2*LEAVES];
  logic [IW-1:0]               node_idx [2*LEAVES];
  logic [VW-1:0]               vote_wide;
  logic [tmq_pkg::TIME_W-1:0]  elapsed;
  logic                        accept, tag_press, tag_none, press_start;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tag_none    = (in_data.touch_tag == tmq_pkg::TAG_NONE);
  assign tag_press   = !tag_none && (in_data.touch_tag != tmq_pkg::TAG_INVALID);
  assign press_start = tag_press && !pressed_r;
  assign start_eff   = press_start ? in_data.now_ms : press_start_r;
  assign elapsed     = in_data.now_ms - start_eff;

  always_comb begin
    for (int i = 0; i < NUM_TAGS; i++) begin
      cnt_nxt[i] = press_start ? '0 : cnt_r[i];
      if (tag_press && (in_data.touch_tag == tmq_pkg::TAG_W'(i + 1)) && (i < NUM_TAGS - 1))
        cnt_nxt[i] = cnt_nxt[i] + 1'b1;
    end
  end

  // argmax tree, lower index kept on ties; pad leaves never win
  always_comb begin
    node_cnt[0] = '0;
    node_idx[0] = '0;
    for (int i = 0; i < LEAVES; i++) begin
      node_cnt[LEAVES + i] = (i < NUM_TAGS) ? cnt_nxt[i] : '0;
      node_idx[LEAVES + i] = IW'(i);
    end
    for (int k = LEAVES - 1; k >= 1; k--) begin
      if (node_cnt[2*k] < node_cnt[2*k + 1]) begin
        node_cnt[k] = node_cnt[2*k + 1];
        node_idx[k] = node_idx[2*k + 1];
      end else begin
        node_cnt[k] = node_cnt[2*k];
        node_idx[k] = node_idx[2*k];
      end
    end
  end

  assign vote_wide = VW'(node_idx[1]) + VW'(1);

  always_comb begin
    pressed_nxt  = pressed_r;
    held_tag_nxt = held_tag_r;
    out_data_nxt = '0;
    if (tag_press) begin
      pressed_nxt = 1'b1;
      if (press_start)
        held_tag_nxt = '0;
      if (elapsed >= tmq_pkg::TIME_W'(hold_ms_r)) begin
        held_tag_nxt           = vote_wide[tmq_pkg::VOTE_W-1:0];
        out_data_nxt.voted_tag = vote_wide[tmq_pkg::VOTE_W-1:0];
      end
    end else if (tag_none && pressed_r) begin
      pressed_nxt                = 1'b0;
      out_data_nxt.voted_tag     = held_tag_r;
      out_data_nxt.release_event = (held_tag_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ms_r   <= tmq_pkg::HOLD_RESET;
      pressed_r   <= 1'b0;
      held_tag_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we)
        hold_ms_r <= cfg_wdata;
      if (accept) begin
        pressed_r  <= pressed_nxt;
        held_tag_r <= held_tag_nxt;
      end
      if (accept)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
      if (press_start)
        press_start_r <= in_data.now_ms;
      for (int i = 0; i < NUM_TAGS; i++)
        cnt_r[i] <= cnt_nxt[i];
    end
  end

  a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word produced no result");

  a_event_has_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.release_event |-> out_data_r.voted_tag != '0)
    else $error("release event with zero tag");

  a_idle_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !pressed_r && tag_none |=> out_data_r == '0)
    else $error("zero tag while idle gave a result");

  a_press_sets_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept && tag_press |=> pressed_r)
    else $error("press not registered");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && tag_none |=> !pressed_r)
    else $error("press not ended by zero tag");

endmodule

// ===== bench/tb_touch_tag_majority_qualifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_tag_majority_qualifier
// Self-checking bench for the touch tag majority qualifier.
// ----------------------------------------------------------------------------
// Polls are queued by the stimulus process and driven on valid/stall with
// random gaps; every accepted poll runs through a local vote predictor and
// each result word is compared field by field with the oldest prediction.
// Covers directed corner cases, random presses under several hold windows
// and a long output stall.
// ----------------------------------------------------------------------------
module tb_touch_tag_majority_qualifier;

  localparam int unsigned NTAGS = tmq_pkg::NUM_TAGS_DEF;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [tmq_pkg::HOLD_W-1:0] cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  tmq_pkg::in_word_t          in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  tmq_pkg::out_word_t         out_data;

  touch_tag_majority_qualifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // predictor state
  logic [tmq_pkg::HOLD_W-1:0] vote_hold = tmq_pkg::HOLD_RESET;
  logic                       pressed = 1'b0;
  logic [tmq_pkg::VOTE_W-1:0] held_tag = '0;
  logic [tmq_pkg::TIME_W-1:0] press_start = '0;
  logic [tmq_pkg::CNT_W-1:0]  tally [NTAGS];

  tmq_pkg::in_word_t  poll_q [$];
  tmq_pkg::out_word_t vote_q [$];
  int                 mismatches = 0;

  bit poll_taken = 1'b0;
  bit vote_taken = 1'b0;
  bit in_idle = 1'b0;
  bit out_idle = 1'b0;
  int in_wait = 0;
  int out_wait = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;

  initial begin
    foreach (tally[i]) tally[i] = '0;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic tmq_pkg::out_word_t predict_vote(input tmq_pkg::in_word_t w);
    tmq_pkg::out_word_t         r;
    int                         best;
    logic [tmq_pkg::TIME_W-1:0] elapsed;
    r = '0;
    if (w.touch_tag != tmq_pkg::TAG_NONE && w.touch_tag != tmq_pkg::TAG_INVALID) begin
      if (!pressed) begin
        foreach (tally[i]) tally[i] = '0;
        held_tag = '0;
        pressed = 1'b1;
        press_start = w.now_ms;
      end
      if (w.touch_tag < NTAGS)
        tally[int'(w.touch_tag) - 1] = tally[int'(w.touch_tag) - 1] + 1'b1;
      elapsed = w.now_ms - press_start;
      if (elapsed >= {16'd0, vote_hold}) begin
        best = 0;
        for (int i = 1; i < NTAGS; i++) begin
          if (tally[best] < tally[i]) best = i;
        end
        held_tag = tmq_pkg::VOTE_W'(best + 1);
        r.voted_tag = held_tag;
      end
    end else if (w.touch_tag == tmq_pkg::TAG_NONE && pressed) begin
      pressed = 1'b0;
      r.voted_tag = held_tag;
      r.release_event = (held_tag != '0);
    end
    return r;
  endfunction

  function automatic int pick_gap(input bit on);
    return on ? int'($urandom_range(0, 8)) : 0;
  endfunction

  // input side
  always @(posedge clk) begin
    poll_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) vote_q.push_back(predict_vote(in_data));
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || poll_taken)) begin
      if (in_wait != 0) begin
        in_valid <= 1'b0;
        in_wait <= in_wait - 1;
      end else if (poll_q.size() != 0) begin
        in_data <= poll_q.pop_front();
        in_valid <= 1'b1;
        in_wait <= pick_gap(in_idle);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side
  always @(posedge clk) begin
    tmq_pkg::out_word_t want;
    vote_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (vote_q.size() == 0) begin
        $error("unexpected result word: voted_tag %0d release_event %0d",
               out_data.voted_tag, out_data.release_event);
        mismatches++;
      end else begin
        want = vote_q.pop_front();
        if (out_data.voted_tag !== want.voted_tag) begin
          $error("voted_tag: expected %0d, got %0d", want.voted_tag, out_data.voted_tag);
          mismatches++;
        end
        if (out_data.release_event !== want.release_event) begin
          $error("release_event: expected %0d, got %0d",
                 want.release_event, out_data.release_event);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    int w;
    if (rst_n) begin
      if (holds_done != holds_asked) begin
        holds_done <= holds_asked;
        hold_left <= 150;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (vote_taken) begin
        w = pick_gap(out_idle);
        out_stall <= (w != 0);
        out_wait <= (w != 0) ? w - 1 : 0;
      end else if (out_wait != 0) begin
        out_wait <= out_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic poll(input logic [tmq_pkg::TAG_W-1:0] tag,
                      input logic [tmq_pkg::TIME_W-1:0] t);
    poll_q.push_back(tmq_pkg::in_word_t'{touch_tag: tag, now_ms: t});
  endtask

  task automatic drain();
    while (poll_q.size() != 0 || in_valid || vote_q.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_hold(input logic [tmq_pkg::HOLD_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    vote_hold = v;
  endtask

  task automatic gen_traffic(input int n);
    int                         made;
    int                         polls;
    int                         span;
    int                         r;
    logic [tmq_pkg::TAG_W-1:0]  lead;
    logic [tmq_pkg::TAG_W-1:0]  tag;
    logic [tmq_pkg::TIME_W-1:0] t;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        poll(tmq_pkg::TAG_W'($urandom_range(0, 255)), $urandom);
        made++;
      end else begin
        polls = $urandom_range(1, 30);
        span = (2 * int'(vote_hold)) / polls + 1;
        lead = tmq_pkg::TAG_W'($urandom_range(1, NTAGS - 1));
        if ($urandom_range(0, 4) == 0)
          t = 32'hFFFF_FFFF - $urandom_range(0, int'(vote_hold) + 40);
        else
          t = $urandom;
        for (int k = 0; k < polls; k++) begin
          r = $urandom_range(0, 99);
          if (r < 55) tag = lead;
          else if (r < 85) tag = tmq_pkg::TAG_W'($urandom_range(1, NTAGS - 1));
          else if (r < 92) tag = tmq_pkg::TAG_INVALID;
          else tag = tmq_pkg::TAG_W'($urandom_range(NTAGS, 254));
          poll(tag, t);
          t += $urandom_range(0, span);
        end
        if ($urandom_range(0, 9) != 0) poll(tmq_pkg::TAG_NONE, t);
        made += polls + 1;
      end
    end
  endtask

  initial begin
    logic [tmq_pkg::TIME_W-1:0] t0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset hold window of 20 ms
    in_idle = 1'b1;
    out_idle = 1'b1;
    poll(tmq_pkg::TAG_NONE, 32'd5);
    poll(tmq_pkg::TAG_INVALID, 32'd6);
    poll(8'd3, 32'd1000);
    poll(8'd3, 32'd1010);
    poll(8'd5, 32'd1019);
    poll(8'd5, 32'd1020);
    poll(tmq_pkg::TAG_INVALID, 32'd1025);
    poll(8'd200, 32'd1030);
    poll(8'd11, 32'd1031);
    poll(8'd12, 32'd1032);
    poll(tmq_pkg::TAG_NONE, 32'd1040);
    poll(tmq_pkg::TAG_NONE, 32'd1041);
    poll(8'd12, 32'd2000);
    poll(8'd254, 32'd2030);
    poll(tmq_pkg::TAG_NONE, 32'd2031);
    poll(8'd4, 32'hFFFF_FFF0);
    poll(8'd4, 32'h0000_0005);
    poll(tmq_pkg::TAG_NONE, 32'h0000_0006);
    poll(8'd8, 32'd500);
    poll(tmq_pkg::TAG_NONE, 32'd505);
    drain();

    write_hold(16'd0);
    poll(8'd9, 32'hA5A5_5A5A);
    poll(8'd1, 32'hA5A5_5A5A);
    poll(tmq_pkg::TAG_NONE, 32'hA5A5_5A5B);
    in_idle = 1'b0;
    out_idle = 1'b1;
    gen_traffic(200);
    drain();

    write_hold(16'hFFFF);
    t0 = $urandom;
    poll(8'd7, t0);
    poll(8'd7, t0 + 32'd65534);
    poll(8'd7, t0 + 32'd65535);
    poll(tmq_pkg::TAG_NONE, t0 + 32'd70000);
    in_idle = 1'b1;
    out_idle = 1'b0;
    gen_traffic(200);
    drain();

    write_hold(16'd1);
    in_idle = 1'b0;
    out_idle = 1'b0;
    gen_traffic(200);
    drain();

    // long output stall while polls keep coming
    write_hold(tmq_pkg::HOLD_W'($urandom_range(2, 200)));
    holds_asked++;
    gen_traffic(150);
    drain();
    in_idle = 1'b1;
    out_idle = 1'b1;
    gen_traffic(200);
    drain();

    write_hold(tmq_pkg::HOLD_W'($urandom_range(0, 65535)));
    in_idle = 1'b1;
    out_idle = 1'b1;
    gen_traffic(150);
    drain();

    write_hold(tmq_pkg::HOLD_RESET);
    in_idle = 1'b1;
    out_idle = 1'b0;
    gen_traffic(300);
    drain();

    if (vote_q.size() != 0) mismatches += vote_q.size();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
